// ===== sv/rcfdc_pkg.sv =====
package rcfdc_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int CH_W        = 11;

    localparam logic [7:0] HDR_BYTE = 8'h0f;
    localparam logic [7:0] FTR_BYTE = 8'h00;

    // stick scaling: trunc(((CH_CENTER - raw) * SCALE_NUM - offset) / 694)
    localparam int CH_CENTER  = 1000;
    localparam int SCALE_NUM  = 100;
    localparam int STEER_OFS  = 6246;
    // floor(x / 694) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 277309
    localparam int DIV_SHIFT  = 27;
    localparam logic [17:0] DIV_RECIP = 18'd193398;

    // switch thresholds: |raw - 1000| >= 694
    localparam int SW_HI_MIN  = 1694;
    localparam int SW_LO_MAX  = 306;

    localparam logic [7:0] DEADBAND_RST = 8'd10;

    typedef enum logic [1:0] {
        SW_MID  = 2'b00,
        SW_UP   = 2'b01,
        SW_DOWN = 2'b11
    } sw_pos_t;

    localparam logic [2:0] STARTUP_NONE    = 3'd0;
    localparam logic [2:0] STARTUP_ENABLE  = 3'd1;
    localparam logic [2:0] STARTUP_STOP    = 3'd5;
    localparam logic [2:0] STARTUP_DISABLE = 3'd6;

    localparam logic [1:0] STOP_NONE = 2'd0;
    localparam logic [1:0] STOP_LOW  = 2'd1;
    localparam logic [1:0] STOP_HIGH = 2'd2;
    localparam logic [1:0] STOP_MID  = 2'd3;

endpackage

// ===== sv/rcfdc_if.sv =====
interface rcfdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;
    logic       quick_stop_enabled;

    modport source (output valid, rx_byte, buffer_end, quick_stop_enabled, input ready);
    modport sink   (input valid, rx_byte, buffer_end, quick_stop_enabled, output ready);
endinterface

interface rcfdc_out_if;
    logic              valid;
    logic              ready;
    logic              frame_valid;
    logic signed [9:0] linear_velocity;
    logic signed [9:0] angular_velocity;
    logic              manual_mode;
    logic              startup_set;
    logic [2:0]        startup_value;
    logic [1:0]        stop_code;

    modport source (output valid, frame_valid, linear_velocity, angular_velocity,
                    manual_mode, startup_set, startup_value, stop_code, input ready);
    modport sink   (input valid, frame_valid, linear_velocity, angular_velocity,
                    manual_mode, startup_set, startup_value, stop_code, output ready);
endinterface

// ===== sv/rc_frame_drive_command.sv =====
// An accepted beat reaches its result on cmd through the input register, the
// decode/scale register and the result register.
// Throughput: one beat per cycle; an end beat waits in the input register while the
// decode and result registers are both full, and rx stalls behind it.
// Reset (rst_n low, async): byte count, channels, switches and held velocities
// clear to zero, deadband threshold to 10, no result pending. No clearing pass.
module rc_frame_drive_command (
    input  logic        clk,
    input  logic        rst_n,
    rcfdc_in_if.sink    rx,
    rcfdc_out_if.source cmd,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import rcfdc_pkg::*;

    logic [7:0]             thr_reg;

    // stage 1: input register and frame buffer
    logic                   s1_vld_reg, s1_vld_next;
    logic [7:0]             s1_byte_reg;
    logic                   s1_end_reg;
    logic                   s1_qs_reg;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]             store_reg [FRAME_BYTES];

    // stage 2: decoded frame
    logic                   s2_vld_reg, s2_vld_next;
    logic                   s2_qs_reg;
    logic                   s2_fv_reg;
    logic signed [8:0]      s2_thr_reg;
    logic signed [8:0]      s2_str_reg;
    sw_pos_t                s2_sw4_reg, s2_sw9_reg, s2_sw11_reg;

    // decision state
    logic signed [8:0]      ch_thr_reg, ch_thr_next;
    logic signed [8:0]      ch_str_reg, ch_str_next;
    sw_pos_t                sw4_reg, sw4_next;
    sw_pos_t                sw9_reg, sw9_next;
    sw_pos_t                sw11_reg, sw11_next;
    sw_pos_t                prev_en_reg, prev_en_next;
    logic signed [9:0]      held_lin_reg, held_lin_next;
    logic signed [9:0]      held_ang_reg, held_ang_next;

    // result register
    logic                   o_vld_reg, o_vld_next;
    logic                   o_fv_reg;
    logic                   o_manual_reg, o_manual_next;
    logic                   o_sset_reg, o_sset_next;
    logic [2:0]             o_sval_reg, o_sval_next;
    logic [1:0]             o_stop_reg, o_stop_next;

    logic                   out_free, s2_go, s2_ready, s1_go, s1_ready, rx_fire;
    logic                   pos_full;
    logic [POS_W-1:0]       pos_inc;
    logic [7:0]             byte_last;
    logic                   frame_ok;
    logic [CH_W-1:0]        raw_thr, raw_str, raw_sw4, raw_sw9, raw_sw11;
    logic signed [8:0]      thr_scaled, str_scaled;

    function automatic logic [7:0] div694(input logic [16:0] m);
        logic [34:0] p;
        p = 35'(m) * 35'(DIV_RECIP);
        return p[DIV_SHIFT+7:DIV_SHIFT];
    endfunction

    function automatic logic signed [8:0] scale_stick(input logic [CH_W-1:0] raw,
                                                      input logic signed [17:0] ofs);
        logic signed [17:0] n;
        logic [16:0]        m;
        logic [7:0]         q;
        n = ($signed(18'(CH_CENTER)) - $signed({7'b0, raw})) * $signed(18'(SCALE_NUM))
            - ofs;
        m = n[17] ? 17'(-n) : 17'(n);
        q = div694(m);
        return n[17] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic sw_pos_t sw_decode(input logic [CH_W-1:0] raw, input logic invert);
        sw_pos_t hi, lo;
        hi = invert ? SW_DOWN : SW_UP;
        lo = invert ? SW_UP : SW_DOWN;
        if (raw >= CH_W'(SW_HI_MIN))
            return hi;
        else if (raw <= CH_W'(SW_LO_MAX))
            return lo;
        else
            return SW_MID;
    endfunction

    function automatic logic [7:0] mag9(input logic signed [8:0] v);
        return v[8] ? 8'(-v) : 8'(v);
    endfunction

    // handshake
    always_comb
    begin
        out_free = !o_vld_reg || cmd.ready;
        s2_go    = s2_vld_reg && out_free;
        s2_ready = !s2_vld_reg || out_free;
        s1_go    = s1_vld_reg && (!s1_end_reg || s2_ready);
        s1_ready = !s1_vld_reg || s1_go;
        rx_fire  = rx.valid && s1_ready;
    end

    assign rx.ready = s1_ready;

    // stage 1: byte count, frame check, channel unpack and scaling
    always_comb
    begin
        pos_full  = (pos_reg == POS_W'(FRAME_BYTES));
        pos_inc   = pos_full ? pos_reg : pos_reg + POS_W'(1);
        byte_last = (pos_reg == POS_W'(FRAME_BYTES - 1)) ? s1_byte_reg
                                                         : store_reg[FRAME_BYTES-1];
        frame_ok  = (pos_inc == POS_W'(FRAME_BYTES)) && (store_reg[0] == HDR_BYTE)
                    && (byte_last == FTR_BYTE);

        raw_thr   = {store_reg[3][5:0],  store_reg[2][7:3]};
        raw_str   = {store_reg[6][3:0],  store_reg[5][7:1]};
        raw_sw4   = {store_reg[7][6:0],  store_reg[6][7:4]};
        raw_sw9   = {store_reg[14][5:0], store_reg[13][7:3]};
        raw_sw11  = {store_reg[17][3:0], store_reg[16][7:1]};

        thr_scaled = scale_stick(raw_thr, 18'sd0);
        str_scaled = scale_stick(raw_str, $signed(18'(STEER_OFS)));

        if (s1_go && s1_end_reg)
            pos_next = '0;
        else if (s1_go)
            pos_next = pos_inc;
        else
            pos_next = pos_reg;

        if (rx_fire)
            s1_vld_next = 1'b1;
        else if (s1_go)
            s1_vld_next = 1'b0;
        else
            s1_vld_next = s1_vld_reg;

        if (s1_go && s1_end_reg)
            s2_vld_next = 1'b1;
        else if (s2_go)
            s2_vld_next = 1'b0;
        else
            s2_vld_next = s2_vld_reg;
    end

    // stage 2: channel update and decisions
    always_comb
    begin
        logic signed [9:0] lin;
        logic signed [9:0] ang;
        logic              manual;

        ch_thr_next  = s2_fv_reg ? s2_thr_reg : ch_thr_reg;
        ch_str_next  = s2_fv_reg ? s2_str_reg : ch_str_reg;
        sw4_next     = s2_fv_reg ? s2_sw4_reg : sw4_reg;
        sw9_next     = s2_fv_reg ? s2_sw9_reg : sw9_reg;
        sw11_next    = s2_fv_reg ? s2_sw11_reg : sw11_reg;
        prev_en_next = s2_fv_reg ? sw11_reg : prev_en_reg;

        lin    = $signed({ch_thr_next[8], ch_thr_next}) + $signed({ch_thr_next, 1'b0});
        ang    = $signed({ch_str_next, 1'b0});
        manual = (sw9_next == SW_UP);

        held_lin_next = held_lin_reg;
        held_ang_next = held_ang_reg;
        if (manual)
        begin
            held_lin_next = (mag9(ch_thr_next) >= thr_reg) ? lin : '0;
            held_ang_next = (mag9(ch_str_next) >= thr_reg) ? ang : '0;
        end
        o_manual_next = manual;

        o_sset_next = 1'b0;
        o_sval_next = STARTUP_NONE;
        if (sw11_next == SW_MID)
        begin
            o_sset_next = 1'b1;
            o_sval_next = STARTUP_STOP;
        end
        else if (sw11_next == SW_UP && prev_en_next != SW_UP)
        begin
            o_sset_next = 1'b1;
            o_sval_next = STARTUP_ENABLE;
        end
        else if (sw11_next == SW_DOWN)
        begin
            o_sset_next = 1'b1;
            o_sval_next = STARTUP_DISABLE;
        end

        o_stop_next = STOP_NONE;
        if (s2_qs_reg)
        begin
            case (sw4_next)
                SW_DOWN: o_stop_next = STOP_LOW;
                SW_UP:   o_stop_next = STOP_HIGH;
                SW_MID:  o_stop_next = STOP_MID;
                default: o_stop_next = STOP_NONE;
            endcase
        end

        if (s2_go)
            o_vld_next = 1'b1;
        else if (cmd.ready)
            o_vld_next = 1'b0;
        else
            o_vld_next = o_vld_reg;
    end

    // control and decision state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= DEADBAND_RST;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            o_vld_reg    <= 1'b0;
            pos_reg      <= '0;
            ch_thr_reg   <= '0;
            ch_str_reg   <= '0;
            sw4_reg      <= SW_MID;
            sw9_reg      <= SW_MID;
            sw11_reg     <= SW_MID;
            prev_en_reg  <= SW_MID;
            held_lin_reg <= '0;
            held_ang_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            o_vld_reg  <= o_vld_next;
            pos_reg    <= pos_next;
            if (s2_go)
            begin
                ch_thr_reg   <= ch_thr_next;
                ch_str_reg   <= ch_str_next;
                sw4_reg      <= sw4_next;
                sw9_reg      <= sw9_next;
                sw11_reg     <= sw11_next;
                prev_en_reg  <= prev_en_next;
                held_lin_reg <= held_lin_next;
                held_ang_reg <= held_ang_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            s1_byte_reg <= rx.rx_byte;
            s1_end_reg  <= rx.buffer_end;
            s1_qs_reg   <= rx.quick_stop_enabled;
        end
        if (s1_go && !pos_full)
            store_reg[pos_reg] <= s1_byte_reg;
        if (s1_go && s1_end_reg)
        begin
            s2_qs_reg   <= s1_qs_reg;
            s2_fv_reg   <= frame_ok;
            s2_thr_reg  <= thr_scaled;
            s2_str_reg  <= str_scaled;
            s2_sw4_reg  <= sw_decode(raw_sw4, 1'b0);
            s2_sw9_reg  <= sw_decode(raw_sw9, 1'b1);
            s2_sw11_reg <= sw_decode(raw_sw11, 1'b1);
        end
        if (s2_go)
        begin
            o_fv_reg     <= s2_fv_reg;
            o_manual_reg <= o_manual_next;
            o_sset_reg   <= o_sset_next;
            o_sval_reg   <= o_sval_next;
            o_stop_reg   <= o_stop_next;
        end
    end

    assign cmd.valid            = o_vld_reg;
    assign cmd.frame_valid      = o_fv_reg;
    assign cmd.linear_velocity  = held_lin_reg;
    assign cmd.angular_velocity = held_ang_reg;
    assign cmd.manual_mode      = o_manual_reg;
    assign cmd.startup_set      = o_sset_reg;
    assign cmd.startup_value    = o_sval_reg;
    assign cmd.stop_code        = o_stop_reg;

endmodule

// ===== sv/rcfdc_checker.sv =====
module rcfdc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              manual_mode,
    input logic signed [9:0] linear_velocity,
    input logic signed [9:0] angular_velocity,
    input logic              startup_set,
    input logic [2:0]        startup_value
);
    import rcfdc_pkg::*;

    logic signed [9:0] last_lin_reg;
    logic signed [9:0] last_ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_lin_reg <= '0;
            last_ang_reg <= '0;
        end
        else if (cmd_valid && cmd_ready)
        begin
            last_lin_reg <= linear_velocity;
            last_ang_reg <= angular_velocity;
        end
    end

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("result beat dropped while stalled");

    a_vel_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !manual_mode |->
            linear_velocity == last_lin_reg && angular_velocity == last_ang_reg)
        else $error("velocities changed outside manual mode");

    a_startup_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && startup_set |->
            startup_value == STARTUP_ENABLE || startup_value == STARTUP_STOP ||
            startup_value == STARTUP_DISABLE)
        else $error("bad startup code");

    a_startup_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !startup_set |-> startup_value == STARTUP_NONE)
        else $error("startup value set without startup_set");

    a_ang_even: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !angular_velocity[0])
        else $error("angular velocity not a multiple of two");

endmodule

bind rc_frame_drive_command rcfdc_checker u_rcfdc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .manual_mode      (cmd.manual_mode),
    .linear_velocity  (cmd.linear_velocity),
    .angular_velocity (cmd.angular_velocity),
    .startup_set      (cmd.startup_set),
    .startup_value    (cmd.startup_value)
);

// ===== test/rcfdc_test_pkg.sv =====
package rcfdc_test_pkg;

    import rcfdc_pkg::*;

    typedef struct packed {
        logic              frame_valid;
        logic signed [9:0] linear_velocity;
        logic signed [9:0] angular_velocity;
        logic              manual_mode;
        logic              startup_set;
        logic [2:0]        startup_value;
        logic [1:0]        stop_code;
    } drive_cmd_t;

    localparam int STICK_CENTER      = 1000;
    localparam int STICK_GAIN        = 100;
    localparam int STICK_DIV         = 694;
    localparam int STEER_TRIM        = 6246;
    localparam int RAW_MASK          = 'h7ff;
    localparam int DEADBAND_AT_RESET = 10;

    class drive_cmd_checker;

        logic [7:0] frame_bytes [FRAME_BYTES];
        int         fill;
        int         throttle;
        int         steer;
        int         sw4;
        int         sw9;
        int         sw11;
        int         last_sw11;
        int         hold_lin;
        int         hold_ang;
        int         deadband;
        drive_cmd_t pending_cmds [$];
        int         mismatches;
        int         checked;
        int         good_frames;

        function new();
            deadband    = DEADBAND_AT_RESET;
            fill        = 0;
            throttle    = 0;
            steer       = 0;
            sw4         = 0;
            sw9         = 0;
            sw11        = 0;
            last_sw11   = 0;
            hold_lin    = 0;
            hold_ang    = 0;
            mismatches  = 0;
            checked     = 0;
            good_frames = 0;
        endfunction

        function void set_deadband(logic [7:0] value);
            deadband = int'(value);
        endfunction

        function int raw_channel(int lo, int lsh, int hi, int hsh);
            logic [31:0] word;
            word = ({24'd0, frame_bytes[lo]} >> lsh) | ({24'd0, frame_bytes[hi]} << hsh);
            return int'(word & RAW_MASK);
        endfunction

        function string show(drive_cmd_t c);
            return $sformatf("valid=%0d lin=%0d ang=%0d manual=%0d set=%0d step=%0d stop=%0d",
                             c.frame_valid, c.linear_velocity, c.angular_velocity,
                             c.manual_mode, c.startup_set, c.startup_value, c.stop_code);
        endfunction

        function void take_beat(logic [7:0] data, logic last, logic qs_en);
            drive_cmd_t c;
            logic       ok;
            int         r_thr;
            int         r_str;
            int         r_s4;
            int         r_s9;
            int         r_s11;
            if (fill < FRAME_BYTES)
            begin
                frame_bytes[fill] = data;
                fill++;
            end
            if (!last)
                return;
            ok = (fill >= FRAME_BYTES) && (frame_bytes[0] == HDR_BYTE)
                 && (frame_bytes[FRAME_BYTES-1] == FTR_BYTE);
            fill = 0;
            if (ok)
            begin
                r_thr     = raw_channel(2, 3, 3, 5);
                r_str     = raw_channel(5, 1, 6, 7);
                r_s4      = raw_channel(6, 4, 7, 4);
                r_s9      = raw_channel(13, 3, 14, 5);
                r_s11     = raw_channel(16, 1, 17, 7);
                last_sw11 = sw11;
                throttle  = ((STICK_CENTER - r_thr) * STICK_GAIN) / STICK_DIV;
                steer     = ((STICK_CENTER - r_str) * STICK_GAIN - STEER_TRIM) / STICK_DIV;
                sw4       = (r_s4 - STICK_CENTER) / STICK_DIV;
                sw9       = -((r_s9 - STICK_CENTER) / STICK_DIV);
                sw11      = -((r_s11 - STICK_CENTER) / STICK_DIV);
                good_frames++;
            end
            c = '0;
            c.frame_valid = ok;
            c.manual_mode = (sw9 == 1);
            if (sw9 == 1)
            begin
                hold_lin = ((throttle < 0 ? -throttle : throttle) >= deadband) ? 3 * throttle : 0;
                hold_ang = ((steer < 0 ? -steer : steer) >= deadband) ? 2 * steer : 0;
            end
            c.linear_velocity  = 10'(hold_lin);
            c.angular_velocity = 10'(hold_ang);
            c.startup_set      = 1'b1;
            if (sw11 == 0)
                c.startup_value = STARTUP_STOP;
            else if (sw11 == 1 && last_sw11 != 1)
                c.startup_value = STARTUP_ENABLE;
            else if (sw11 == -1)
                c.startup_value = STARTUP_DISABLE;
            else
            begin
                c.startup_set   = 1'b0;
                c.startup_value = STARTUP_NONE;
            end
            c.stop_code = STOP_NONE;
            if (qs_en)
            begin
                if (sw4 == -1)
                    c.stop_code = STOP_LOW;
                else if (sw4 == 1)
                    c.stop_code = STOP_HIGH;
                else if (sw4 == 0)
                    c.stop_code = STOP_MID;
            end
            pending_cmds.push_back(c);
        endfunction

        function void check_cmd(drive_cmd_t got, realtime at);
            drive_cmd_t want;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0.3f ns: command with none expected: %s", at, show(got));
                return;
            end
            want = pending_cmds.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                $display("%0.3f ns: command mismatch expected %s", at, show(want));
                $display("%0.3f ns:                  actual   %s", at, show(got));
            end
        endfunction

    endclass

endpackage

// ===== test/rc_frame_drive_command_test.sv =====
module rc_frame_drive_command_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rcfdc_pkg::*;
    import rcfdc_test_pkg::*;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BEATS    = 64;
    localparam int PHASE_CMDS     = 2;
    localparam int STALL_LEN      = 400;
    localparam int BURST_BUFFERS  = 40;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_HEADER,
        FRAME_BAD_FOOTER
    } frame_kind_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    rcfdc_in_if  rx ();
    rcfdc_out_if cmd ();

    drive_cmd_checker cmd_check;
    drive_cmd_t       got_cmd;

    int   src_idle_pct;
    int   snk_idle_pct;
    logic pressure_on;
    logic pressure_done;
    int   beats_in    = 0;
    int   cmds_out    = 0;
    int   idle_cycles = 0;

    rc_frame_drive_command u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : sink_drive
        int held;
        held          = 0;
        pressure_done = 1'b0;
        cmd.ready     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_on && !pressure_done)
            begin
                cmd.ready <= 1'b0;
                held++;
                if (held >= STALL_LEN)
                    pressure_done = 1'b1;
            end
            else
                cmd.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            cmd_check.take_beat(rx.rx_byte, rx.buffer_end, rx.quick_stop_enabled);
            beats_in++;
        end
        if (cmd.valid && cmd.ready)
        begin
            got_cmd.frame_valid      = cmd.frame_valid;
            got_cmd.linear_velocity  = cmd.linear_velocity;
            got_cmd.angular_velocity = cmd.angular_velocity;
            got_cmd.manual_mode      = cmd.manual_mode;
            got_cmd.startup_set      = cmd.startup_set;
            got_cmd.startup_value    = cmd.startup_value;
            got_cmd.stop_code        = cmd.stop_code;
            cmd_check.check_cmd(got_cmd, $realtime);
            cmds_out++;
        end
        if ((rx.valid && rx.ready) || (cmd.valid && cmd.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("rc_frame_drive_command regression: fail");
        $finish;
    end

    // called and returns at a falling edge
    task automatic send_beat(input logic [7:0] data, input logic last, input logic qs_en);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx.valid <= 1'b0;
            @(negedge clk);
        end
        rx.valid              <= 1'b1;
        rx.rx_byte            <= data;
        rx.buffer_end         <= last;
        rx.quick_stop_enabled <= qs_en;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_buffer(input int thr_raw, input int str_raw, input int s4_raw,
                               input int s9_raw, input int s11_raw, input logic qs_en,
                               input frame_kind_t kind, input int len);
        logic [10:0]  ch [16];
        logic [175:0] payload;
        logic [7:0]   frm [FRAME_BYTES];
        logic [7:0]   data;
        for (int k = 0; k < 16; k++)
            ch[k] = 11'($urandom);
        ch[1]  = 11'(thr_raw);
        ch[3]  = 11'(str_raw);
        ch[4]  = 11'(s4_raw);
        ch[9]  = 11'(s9_raw);
        ch[11] = 11'(s11_raw);
        for (int k = 0; k < 16; k++)
            payload[11*k +: 11] = ch[k];
        frm[0] = HDR_BYTE;
        for (int j = 1; j <= 22; j++)
            frm[j] = payload[8*(j-1) +: 8];
        frm[23] = 8'($urandom);
        frm[FRAME_BYTES-1] = FTR_BYTE;
        if (kind == FRAME_BAD_HEADER)
        begin
            do
                frm[0] = 8'($urandom);
            while (frm[0] == HDR_BYTE);
        end
        if (kind == FRAME_BAD_FOOTER)
            frm[FRAME_BYTES-1] = 8'($urandom_range(255, 1));
        for (int i = 0; i < len; i++)
        begin
            data = (i < FRAME_BYTES) ? frm[i] : 8'($urandom);
            send_beat(data, i == len - 1, (i == len - 1) ? qs_en : 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        rx.valid <= 1'b0;
        while (cmd_check.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int stick_raw();
        if ($urandom_range(1))
            return $urandom_range(2047, 0);
        return $urandom_range(1080, 920);
    endfunction

    function automatic int switch_raw();
        int edges [4] = '{306, 307, 1693, 1694};
        case ($urandom_range(7))
            0:       return edges[$urandom_range(3)];
            1, 2, 3: return $urandom_range(306, 0);
            4, 5:    return $urandom_range(1693, 307);
            default: return $urandom_range(2047, 1694);
        endcase
    endfunction

    initial
    begin : stimulus
        int          base_beats;
        int          base_cmds;
        int          pick;
        int          len;
        logic [7:0]  band;
        frame_kind_t kind;

        cmd_check             = new();
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        rx.valid              = 1'b0;
        rx.rx_byte            = '0;
        rx.buffer_end         = 1'b0;
        rx.quick_stop_enabled = 1'b0;
        pressure_on           = 1'b0;
        src_idle_pct          = 8;
        snk_idle_pct          = 84;

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed buffers at the reset deadband
        send_buffer(1000, 1000, 1000, 1000, 1000, 1'b1, FRAME_GOOD, 1);
        send_buffer(0, 0, 1000, 0, 1000, 1'b1, FRAME_GOOD, FRAME_BYTES);
        send_buffer(2047, 2047, 2047, 306, 0, 1'b1, FRAME_GOOD, FRAME_BYTES);
        send_buffer(1000, 1000, 0, 2047, 306, 1'b1, FRAME_GOOD, FRAME_BYTES);
        send_buffer(931, 869, 306, 0, 1000, 1'b1, FRAME_GOOD, FRAME_BYTES);
        send_buffer(930, 868, 1694, 0, 1000, 1'b1, FRAME_GOOD, FRAME_BYTES);
        send_buffer(1070, 1007, 1693, 0, 0, 1'b1, FRAME_GOOD, FRAME_BYTES);
        send_buffer(1069, 1006, 307, 0, 1000, 1'b0, FRAME_GOOD, FRAME_BYTES);
        send_buffer(500, 1500, 1000, 2047, 0, 1'b1, FRAME_GOOD, FRAME_BYTES);
        // rejected frames repeat the enable edge from the held switch state
        send_buffer(1000, 1000, 1000, 1000, 1000, 1'b1, FRAME_BAD_HEADER, FRAME_BYTES);
        send_buffer(1000, 1000, 1000, 1000, 1000, 1'b1, FRAME_BAD_FOOTER, FRAME_BYTES);
        send_buffer(1000, 1000, 1000, 1000, 2047, 1'b1, FRAME_GOOD, FRAME_BYTES + 5);
        send_buffer(1000, 1000, 1000, 1000, 1000, 1'b1, FRAME_GOOD, FRAME_BYTES - 1);
        send_buffer(100, 1900, 0, 306, 307, 1'b1, FRAME_GOOD, FRAME_BYTES);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            src_idle_pct = (p < 2) ? 8 : (p < 4) ? 84 : 0;
            snk_idle_pct = (p < 2) ? 84 : (p < 4) ? 8 : 0;
            case (p)
                0:       band = 8'd0;
                1:       band = 8'd255;
                3:       band = 8'd1;
                5:       band = 8'd10;
                default: band = 8'($urandom_range(254, 2));
            endcase
            wait_drained();
            cfg_we    <= 1'b1;
            cfg_wdata <= band;
            cmd_check.set_deadband(band);
            @(negedge clk);
            cfg_we <= 1'b0;
            base_beats = beats_in;
            base_cmds  = cmds_out;

            if (p == 4)
            begin
                // receiver stalls while short buffers keep coming
                pressure_on <= 1'b1;
                repeat (BURST_BUFFERS)
                    send_buffer(stick_raw(), stick_raw(), switch_raw(), switch_raw(),
                                switch_raw(), 1'($urandom), FRAME_BAD_HEADER, 1);
                rx.valid <= 1'b0;
                wait (pressure_done);
                @(negedge clk);
                pressure_on <= 1'b0;
            end

            while (beats_in - base_beats < PHASE_BEATS || cmds_out - base_cmds < PHASE_CMDS)
            begin
                pick = $urandom_range(99);
                kind = FRAME_GOOD;
                len  = FRAME_BYTES;
                if (pick >= 93)
                    kind = FRAME_BAD_FOOTER;
                else if (pick >= 86)
                    kind = FRAME_BAD_HEADER;
                else if (pick >= 78)
                    len = $urandom_range(FRAME_BYTES - 1, 1);
                else if (pick >= 70)
                    len = $urandom_range(FRAME_BYTES + 7, FRAME_BYTES + 1);
                send_buffer(stick_raw(), stick_raw(), switch_raw(), switch_raw(), switch_raw(),
                            1'($urandom), kind, len);
            end
        end

        wait_drained();
        $display("covered %0d beats, %0d commands checked, %0d well-formed frames decoded",
                 beats_in, cmd_check.checked, cmd_check.good_frames);
        $display("deadband 0 to 255, three idle mixes, one %0d-cycle receiver stall",
                 STALL_LEN);
        if (cmd_check.mismatches == 0 && cmd_check.pending_cmds.size() == 0)
            $display("rc_frame_drive_command regression: pass");
        else
            $display("rc_frame_drive_command regression: fail");
        $finish;
    end

endmodule
